FILE: design/bba_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the buddy block allocator.
// ---------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_ORDER_DEF = 10;
    localparam int MAX_ORDER_LIM = 16;
    localparam int BLOCK_BYTES   = 4096;
    localparam int HEADER_BYTES  = 16;
    localparam int PAGE_SHIFT    = $clog2(BLOCK_BYTES);
    localparam int ADDR_W        = 48;
    localparam int SIZE_W        = 32;
    localparam int WORD_W        = 32;
    localparam int ORDER_W       = 5;
    localparam int PAGE_W        = MAX_ORDER_LIM;
    localparam int FIFO_DEPTH    = 2;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_NOT_ALOC = 3'd4;

    // request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        OP_ERR   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } op_t;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] block_address;
    } result_t;

    // classified command passed from front to back
    typedef struct packed {
        op_t                op;
        logic [2:0]         status;
        logic [ORDER_W-1:0] order;
        logic [PAGE_W-1:0]  page;
    } cmd_t;

endpackage

FILE: design/buddy_block_allocator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// buddy_block_allocator_unit
// Binary buddy allocator: per-level free bitmaps and a per-page order store.
//
//   port group   direction  transaction
//   start/req    in         request accepted when start && !busy
//   done/result  out        one result, valid for the single cycle of done
//   cfg_*        in         register write when cfg_we is high
//
// Front stage registers a request and classifies it from that register; it
// takes no new request while it holds one. A 2-entry queue feeds the back.
// The back sequencer pops a command in IDLE and answers an error caught in
// front there; on an allocate it scans one bitmap word per ACHK visit, reads
// and writes a bitmap word for each split (SRD, SWR) and records the page
// (APG); on a free it checks the page store (FCHK) and visits one level per
// MCHK step. At MAX_ORDER 10 the longest allocate is a full scan up from
// level 0, then 10 splits. After reset and after any register write both
// stores are swept clear with busy high. Results cannot be stalled by the
// receiver.
// ---------------------------------------------------------------------------
module buddy_block_allocator_unit #(
    parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  bba_pkg::req_t              req,
    output logic                       done,
    output bba_pkg::result_t           result,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [bba_pkg::ADDR_W-1:0] cfg_data
);

    localparam int LW = $clog2(MAX_ORDER+1);

    localparam logic REG_TOP  = 1'b0;
    localparam logic REG_BASE = 1'b1;

    logic [LW-1:0]              top_reg;
    logic [bba_pkg::ADDR_W-1:0] base_reg;

    logic          accept;
    logic          front_busy;
    logic          push;
    bba_pkg::cmd_t cmd_in;
    bba_pkg::cmd_t cmd_out;
    logic          q_empty;
    logic          q_full;
    logic          pop;
    logic          clearing;

    assign busy   = clearing || front_busy || q_full;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= LW'(MAX_ORDER);
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TOP)
            begin
                top_reg <= ({1'b0, cfg_data[3:0]} > 5'(MAX_ORDER)) ? LW'(MAX_ORDER)
                                                                 : LW'(cfg_data[3:0]);
            end
            else if (cfg_index == REG_BASE)
            begin
                base_reg <= cfg_data;
            end
        end
    end

    bba_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .top    (top_reg),
        .base   (base_reg),
        .busy   (front_busy),
        .push   (push),
        .cmd    (cmd_in)
    );

    bba_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd_in),
        .pop   (pop),
        .dout  (cmd_out),
        .empty (q_empty),
        .full  (q_full)
    );

    bba_back #(
        .MAX_ORDER (MAX_ORDER)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (cfg_we),
        .top         (top_reg),
        .base        (base_reg),
        .cmd         (cmd_out),
        .empty       (q_empty),
        .pop         (pop),
        .clearing    (clearing),
        .done        (done),
        .result      (result)
    );

endmodule

FILE: design/bba_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bba_fifo
// Short command queue between the classify front and the execute back.
// ---------------------------------------------------------------------------
module bba_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bba_pkg::cmd_t din,
    input  logic          pop,
    output bba_pkg::cmd_t dout,
    output logic          empty,
    output logic          full
);

    localparam int AW = $clog2(bba_pkg::FIFO_DEPTH);

    bba_pkg::cmd_t    mem_reg [0:bba_pkg::FIFO_DEPTH-1];
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    rp_reg;
    logic [AW:0]      cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (AW+1)'(bba_pkg::FIFO_DEPTH));
    assign dout  = mem_reg[rp_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= din;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: design/bba_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bba_front
// Takes requests, computes block order or page index and catches
// size and address errors before queueing.
// ---------------------------------------------------------------------------
module bba_front #(
    parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  bba_pkg::req_t               req,
    input  logic [$clog2(MAX_ORDER+1)-1:0] top,
    input  logic [bba_pkg::ADDR_W-1:0]  base,
    output logic                        busy,
    output logic                        push,
    output bba_pkg::cmd_t               cmd
);

    localparam int LW = $clog2(MAX_ORDER+1);
    localparam int PS = bba_pkg::PAGE_SHIFT;
    localparam int AW = bba_pkg::ADDR_W;

    logic           s1_valid_reg;
    bba_pkg::req_t  s1_req_reg;

    logic [AW:0]    off_ext;
    logic [5:0]     shamt;
    logic [AW-1:0]  off;
    logic [AW-1:0]  off2;
    logic           oor;
    logic [32:0]    total;
    logic [32:0]    pages;
    logic [32:0]    p1;
    logic [5:0]     k;

    assign busy = s1_valid_reg;
    assign push = s1_valid_reg;

    // request stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req;
        end
    end

    // free address decode
    always_comb
    begin
        off_ext = {1'b0, s1_req_reg.free_address} - {1'b0, base};
        shamt   = 6'(top) + 6'(PS);
        off     = off_ext[AW-1:0];
        oor     = off_ext[AW] || ((off >> shamt) != '0);
        off2    = off - AW'(bba_pkg::HEADER_BYTES);
    end

    // allocate order: ceil log2 of page count
    always_comb
    begin
        total = {1'b0, s1_req_reg.size_bytes} + 33'(bba_pkg::HEADER_BYTES);
        pages = (total + 33'(bba_pkg::BLOCK_BYTES - 1)) >> PS;
        p1    = pages - 33'd1;
        k     = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (p1[i])
            begin
                k = 6'(i + 1);
            end
        end
    end

    // classify
    always_comb
    begin
        cmd.op     = bba_pkg::OP_ERR;
        cmd.status = bba_pkg::ST_OK;
        cmd.order  = bba_pkg::ORDER_W'(k);
        cmd.page   = off2[PS+bba_pkg::PAGE_W-1:PS];
        if (s1_req_reg.req_type == bba_pkg::REQ_FREE)
        begin
            if (oor)
            begin
                cmd.status = bba_pkg::ST_RANGE;
            end
            else if (off < AW'(bba_pkg::HEADER_BYTES) || off2[PS-1:0] != '0)
            begin
                cmd.status = bba_pkg::ST_NOT_ALOC;
            end
            else
            begin
                cmd.op = bba_pkg::OP_FREE;
            end
        end
        else
        begin
            if (s1_req_reg.size_bytes == '0)
            begin
                cmd.status = bba_pkg::ST_ZERO;
            end
            else if (k > 6'(top))
            begin
                cmd.status = bba_pkg::ST_NO_SPACE;
            end
            else
            begin
                cmd.op = bba_pkg::OP_ALLOC;
            end
        end
    end

endmodule

FILE: design/bba_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bba_back
// Executes queued commands against the free bitmaps and the page order
// store; also sweeps both stores clear after reset or reconfiguration.
// ---------------------------------------------------------------------------
module bba_back #(
    parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear_start,
    input  logic [$clog2(MAX_ORDER+1)-1:0] top,
    input  logic [bba_pkg::ADDR_W-1:0]     base,
    input  bba_pkg::cmd_t                  cmd,
    input  logic                           empty,
    output logic                           pop,
    output logic                           clearing,
    output logic                           done,
    output bba_pkg::result_t               result
);

    localparam int LW      = $clog2(MAX_ORDER+1);
    localparam int PW      = MAX_ORDER;
    localparam int NPAGES  = 1 << MAX_ORDER;
    localparam int POW     = $clog2(MAX_ORDER+2);
    localparam int IW      = (MAX_ORDER > 5) ? MAX_ORDER : 6;
    localparam int WAW     = IW - 5;
    localparam int RW      = LW + WAW;
    localparam int FM_ROWS = 1 << RW;
    localparam int CLR_N   = (FM_ROWS > NPAGES) ? FM_ROWS : NPAGES;
    localparam int CW      = $clog2(CLR_N) + 1;
    localparam int PS      = bba_pkg::PAGE_SHIFT;
    localparam int AW      = bba_pkg::ADDR_W;
    localparam int WW      = bba_pkg::WORD_W;

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_ACHK = 8'b0000_0100,
        S_SRD  = 8'b0000_1000,
        S_SWR  = 8'b0001_0000,
        S_APG  = 8'b0010_0000,
        S_FCHK = 8'b0100_0000,
        S_MCHK = 8'b1000_0000
    } bst_t;

    bst_t               state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [LW-1:0]      lvl_reg, lvl_next;
    logic [LW-1:0]      k_reg, k_next;
    logic [WAW-1:0]     word_reg, word_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [PW-1:0]      page_reg, page_next;
    logic               done_reg, done_next;
    bba_pkg::result_t   res_reg, res_next;

    logic [WW-1:0]      fm_mem [0:FM_ROWS-1];
    logic [POW-1:0]     po_mem [0:NPAGES-1];
    logic [WW-1:0]      fm_q;
    logic [POW-1:0]     po_q;

    logic               fm_we;
    logic [RW-1:0]      fm_wa, fm_ra;
    logic [WW-1:0]      fm_wd;
    logic               po_we;
    logic [PW-1:0]      po_wa, po_ra;
    logic [POW-1:0]     po_wd;

    logic [4:0]         low_bit;
    logic [4:0]         bbit;
    logic [POW-1:0]     flvl;
    logic [PW-1:0]      fidx;
    logic               fbad;
    logic [IW-1:0]      fidx_w;
    logic [IW-1:0]      midx;

    // bitmap row of a level and word
    function automatic logic [RW-1:0] row_of(input logic [LW-1:0] l,
                                             input logic [WAW-1:0] w);
        row_of = {l, w};
    endfunction

    // last bitmap word that holds blocks of level l
    function automatic logic [WAW-1:0] last_word(input logic [LW-1:0] t,
                                                 input logic [LW-1:0] l);
        logic [LW-1:0] d;
        d = t - l;
        if (d >= LW'(5))
        begin
            last_word = WAW'((32'd1 << (32'(d) - 32'd5)) - 32'd1);
        end
        else
        begin
            last_word = '0;
        end
    endfunction

    assign clearing = (state_reg == S_CLR);
    assign done     = done_reg;
    assign result   = res_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            fm_mem[fm_wa] <= fm_wd;
        end
        fm_q <= fm_mem[fm_ra];
    end

    always_ff @(posedge clk)
    begin
        if (po_we)
        begin
            po_mem[po_wa] <= po_wd;
        end
        po_q <= po_mem[po_ra];
    end

    // lowest set bit of the bitmap word
    always_comb
    begin
        low_bit = '0;
        for (int i = WW - 1; i >= 0; i--)
        begin
            if (fm_q[i])
            begin
                low_bit = 5'(i);
            end
        end
    end

    // page order decode for a free
    always_comb
    begin
        flvl   = po_q - POW'(1);
        fidx   = page_reg & ~({PW{1'b1}} << flvl);
        fbad   = (po_q == '0) || (flvl > POW'(top)) || (fidx != '0);
        fidx_w = IW'(page_reg >> flvl);
        bbit   = idx_reg[4:0] ^ 5'd1;
        midx   = idx_reg >> 1;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lvl_next   = lvl_reg;
        k_next     = k_reg;
        word_next  = word_reg;
        idx_next   = idx_reg;
        page_next  = page_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        pop        = 1'b0;
        fm_we      = 1'b0;
        fm_wa      = '0;
        fm_wd      = '0;
        fm_ra      = '0;
        po_we      = 1'b0;
        po_wa      = '0;
        po_wd      = '0;
        po_ra      = '0;

        case (state_reg)
            S_CLR:
            begin
                if (cnt_reg < CW'(FM_ROWS))
                begin
                    fm_we = 1'b1;
                    fm_wa = cnt_reg[RW-1:0];
                    fm_wd = (cnt_reg[RW-1:0] == row_of(top, '0)) ? WW'(1) : '0;
                end
                if (cnt_reg < CW'(NPAGES))
                begin
                    po_we = 1'b1;
                    po_wa = cnt_reg[PW-1:0];
                end
                if (cnt_reg == CW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    case (cmd.op)
                        bba_pkg::OP_ALLOC:
                        begin
                            lvl_next   = LW'(cmd.order);
                            k_next     = LW'(cmd.order);
                            word_next  = '0;
                            fm_ra      = row_of(LW'(cmd.order), '0);
                            state_next = S_ACHK;
                        end
                        bba_pkg::OP_FREE:
                        begin
                            page_next  = PW'(cmd.page);
                            po_ra      = PW'(cmd.page);
                            state_next = S_FCHK;
                        end
                        default:
                        begin
                            done_next              = 1'b1;
                            res_next.status        = cmd.status;
                            res_next.block_address = '0;
                        end
                    endcase
                end
            end

            // scan level bitmaps word by word
            S_ACHK:
            begin
                if (fm_q != '0)
                begin
                    fm_we = 1'b1;
                    fm_wa = row_of(lvl_reg, word_reg);
                    fm_wd = fm_q & ~(WW'(1) << low_bit);
                    if (lvl_reg == k_reg)
                    begin
                        idx_next   = {word_reg, low_bit};
                        state_next = S_APG;
                    end
                    else
                    begin
                        idx_next   = {word_reg, low_bit} << 1;
                        lvl_next   = lvl_reg - 1'b1;
                        state_next = S_SRD;
                    end
                end
                else if (word_reg != last_word(top, lvl_reg))
                begin
                    word_next = word_reg + 1'b1;
                    fm_ra     = row_of(lvl_reg, word_reg + 1'b1);
                end
                else if (lvl_reg != top)
                begin
                    lvl_next  = lvl_reg + 1'b1;
                    word_next = '0;
                    fm_ra     = row_of(lvl_reg + 1'b1, '0);
                end
                else
                begin
                    done_next              = 1'b1;
                    res_next.status        = bba_pkg::ST_NO_SPACE;
                    res_next.block_address = '0;
                    state_next             = S_IDLE;
                end
            end

            // split: mark upper half free at each lower level
            S_SRD:
            begin
                fm_ra      = row_of(lvl_reg, idx_reg[IW-1:5]);
                state_next = S_SWR;
            end

            S_SWR:
            begin
                fm_we = 1'b1;
                fm_wa = row_of(lvl_reg, idx_reg[IW-1:5]);
                fm_wd = fm_q | (WW'(1) << (idx_reg[4:0] | 5'd1));
                if (lvl_reg == k_reg)
                begin
                    state_next = S_APG;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    idx_next   = idx_reg << 1;
                    state_next = S_SRD;
                end
            end

            S_APG:
            begin
                po_we                  = 1'b1;
                po_wa                  = PW'(idx_reg << k_reg);
                po_wd                  = POW'(k_reg) + POW'(1);
                done_next              = 1'b1;
                res_next.status        = bba_pkg::ST_OK;
                res_next.block_address = base
                    + (AW'(PW'(idx_reg << k_reg)) << PS)
                    + AW'(bba_pkg::HEADER_BYTES);
                state_next             = S_IDLE;
            end

            S_FCHK:
            begin
                if (fbad)
                begin
                    done_next              = 1'b1;
                    res_next.status        = bba_pkg::ST_NOT_ALOC;
                    res_next.block_address = '0;
                    state_next             = S_IDLE;
                end
                else
                begin
                    po_we      = 1'b1;
                    po_wa      = page_reg;
                    lvl_next   = LW'(flvl);
                    idx_next   = fidx_w;
                    fm_ra      = row_of(LW'(flvl), fidx_w[IW-1:5]);
                    state_next = S_MCHK;
                end
            end

            // merge with free buddies level by level
            S_MCHK:
            begin
                fm_we = 1'b1;
                fm_wa = row_of(lvl_reg, idx_reg[IW-1:5]);
                if (lvl_reg != top && fm_q[bbit])
                begin
                    fm_wd    = fm_q & ~(WW'(1) << bbit);
                    lvl_next = lvl_reg + 1'b1;
                    idx_next = midx;
                    fm_ra    = row_of(lvl_reg + 1'b1, midx[IW-1:5]);
                end
                else
                begin
                    fm_wd                  = fm_q | (WW'(1) << idx_reg[4:0]);
                    done_next              = 1'b1;
                    res_next.status        = bba_pkg::ST_OK;
                    res_next.block_address = '0;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLR;
                cnt_next   = '0;
            end
        endcase

        if (clear_start)
        begin
            state_next = S_CLR;
            cnt_next   = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        lvl_reg  <= lvl_next;
        k_reg    <= k_next;
        word_reg <= word_next;
        idx_reg  <= idx_next;
        page_reg <= page_next;
        res_reg  <= res_next;
    end

endmodule
